FILE: rtl/brc_pkg.sv
`default_nettype none
package brc_pkg;

  localparam int unsigned DivSteps  = 64;
  localparam int unsigned DenW      = 31;
  localparam int unsigned Latency   = 85;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 56;

  localparam logic [CfgIdxW-1:0] CFG_TEMP_CALIB    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_CALIB_A = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_CALIB_B = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_CALIB_C = 2'd3;

  // Reciprocal of ten, exact for the report range when shifted right by 19.
  localparam logic [15:0] RecipTen      = 16'd52429;
  localparam int unsigned RecipTenShift = 19;

endpackage
`default_nettype wire

FILE: rtl/barometer_reading_compensation.sv
`default_nettype none
// Compensates one raw pressure and temperature pair per cycle unless the output stalls, using
// the factory calibration words in the four configuration registers. A result passes through
// 85 register stages, most of them in the 64-stage restoring divider, one quotient bit per
// stage, that sits between the multiplier stages that form the divisor and the pressure
// correction terms.
// A stalled output holds the whole pipeline, so nothing is lost or repeated. A zero divisor
// gives pressure 0 with the invalid flag in tuser; the temperature fields stay valid.
module barometer_reading_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [brc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [brc_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // raw_pressure [19:0], raw_temperature [39:20]
  input  wire logic [brc_pkg::InDataW-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // pressure_pa [23:0], temperature_centi [39:24], temperature_report [51:40], zeros above
  output logic [brc_pkg::OutDataW-1:0]       m_tdata,
  // pressure_invalid [0]
  output logic                               m_tuser
);
  import brc_pkg::*;

  typedef struct packed {
    logic [15:0] t16;
    logic [11:0] report;
  } temp_side_t;

  typedef struct packed {
    logic inv;
    logic neg;
  } div_side_t;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [15:0] press_calib_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_CALIB:    temp_calib    <= cfg_data[47:0];
        CFG_PRESS_CALIB_A: press_calib_a <= cfg_data;
        CFG_PRESS_CALIB_B: press_calib_b <= cfg_data;
        CFG_PRESS_CALIB_C: press_calib_c <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib[15:0];
  assign t2 = $signed(temp_calib[31:16]);
  assign t3 = $signed(temp_calib[47:32]);
  assign p1 = press_calib_a[15:0];
  assign p2 = $signed(press_calib_a[31:16]);
  assign p3 = $signed(press_calib_a[47:32]);
  assign p4 = $signed(press_calib_a[63:48]);
  assign p5 = $signed(press_calib_b[15:0]);
  assign p6 = $signed(press_calib_b[31:16]);
  assign p7 = $signed(press_calib_b[47:32]);
  assign p8 = $signed(press_calib_b[63:48]);
  assign p9 = $signed(press_calib_c);

  logic              adv;
  logic [Latency-1:0] vld;

  assign adv      = !vld[Latency-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Latency-2:0], s_tvalid};
    end
  end

  logic [19:0] raw_p, raw_t;
  assign raw_p = s_tdata[19:0];
  assign raw_t = s_tdata[39:20];

  logic signed [17:0] s1_a;
  logic signed [16:0] s1_b;
  logic        [20:0] s1_ap;
  logic signed [33:0] s2_m1, s2_bb;
  logic signed [22:0] s3_v1, s4_v1;
  logic signed [21:0] s3_sq;
  logic signed [37:0] s4_m2;
  logic signed [25:0] s5_fine;
  logic signed [15:0] s6_t16, s7_t16, s8_t16, s9_t16;
  logic signed [26:0] s6_x1;
  logic signed [53:0] s7_xsq;
  logic signed [42:0] s7_x1p5, s7_x1p2;
  logic signed [16:0] s7_tr;
  logic               s7_rneg, s8_rneg;
  logic        [31:0] s8_rq;
  logic        [11:0] s9_report;
  logic signed [63:0] s8_x2part, s9_x2part, s8_x1p2s, s9_x1p2s;
  logic signed [63:0] s10_x2, s10_x1n;
  logic        [63:0] s11_y0, s11_nsub;
  logic        [20:0] ap_dly [0:8];

  logic signed [28:0] f5;
  logic signed [20:0] t21;
  logic signed [15:0] t16_next;

  assign f5  = 29'(s5_fine) * 29'sd5 + 29'sd128;
  assign t21 = 21'(f5 >>> 8);

  always_comb begin
    if (t21 > 21'sd32767) begin
      t16_next = 16'sh7fff;
    end else if (t21 < -21'sd32768) begin
      t16_next = 16'sh8000;
    end else begin
      t16_next = t21[15:0];
    end
  end

  logic [63:0] mul6_p, mul3_p, mulp1_p, mulk_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a      <= $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_b      <= $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
      s1_ap     <= 21'd1048576 - {1'b0, raw_p};
      s2_m1     <= s1_a * t2;
      s2_bb     <= s1_b * s1_b;
      s3_v1     <= 23'(s2_m1 >>> 11);
      s3_sq     <= 22'(s2_bb >>> 12);
      s4_m2     <= s3_sq * t3;
      s4_v1     <= s3_v1;
      s5_fine   <= 26'(s4_v1) + 26'(s4_m2 >>> 14);
      s6_t16    <= t16_next;
      s6_x1     <= 27'(s5_fine) - 27'sd128000;
      s7_xsq    <= s6_x1 * s6_x1;
      s7_x1p5   <= s6_x1 * p5;
      s7_x1p2   <= s6_x1 * p2;
      s7_t16    <= s6_t16;
      s7_tr     <= 17'(s6_t16) + 17'sd4000;
      s7_rneg   <= s6_t16 < -16'sd4000;
      s8_t16    <= s7_t16;
      s8_rneg   <= s7_rneg;
      s8_rq     <= s7_tr[15:0] * RecipTen;
      s8_x2part <= (64'(s7_x1p5) <<< 17) + (64'(p4) <<< 35);
      s8_x1p2s  <= 64'(s7_x1p2) <<< 12;
      s9_t16    <= s8_t16;
      s9_report <= s8_rneg ? 12'd0 : 12'(s8_rq >> RecipTenShift);
      s9_x2part <= s8_x2part;
      s9_x1p2s  <= s8_x1p2s;
      s10_x2    <= $signed(mul6_p) + s9_x2part;
      s10_x1n   <= ($signed(mul3_p) >>> 8) + s9_x1p2s;
      s11_y0    <= 64'h0000_8000_0000_0000 + s10_x1n;
      s11_nsub  <= 64'({ap_dly[8], 31'd0}) - s10_x2;
      ap_dly[0] <= s1_ap;
      for (int i = 1; i < 9; i++) begin
        ap_dly[i] <= ap_dly[i-1];
      end
    end
  end

  brc_mul64 u_mul6 (
    .clk(clk), .en(adv), .a(64'(s7_xsq)), .b(64'(p6)), .p(mul6_p)
  );
  brc_mul64 u_mul3 (
    .clk(clk), .en(adv), .a(64'(s7_xsq)), .b(64'(p3)), .p(mul3_p)
  );
  brc_mul64 u_mulp1 (
    .clk(clk), .en(adv), .a(s11_y0), .b(64'(p1)), .p(mulp1_p)
  );
  brc_mul64 u_mulk (
    .clk(clk), .en(adv), .a(s11_nsub), .b(64'd3125), .p(mulk_p)
  );

  logic signed [DenW-1:0] d_full;
  logic        [DenW-1:0] s14_dmag;
  logic        [63:0]     s14_nmag;
  div_side_t              s14_side;
  logic        [63:0]     quo_mag;

  assign d_full = DenW'($signed(mulp1_p) >>> 33);

  always_ff @(posedge clk) begin
    if (adv) begin
      s14_dmag     <= d_full[DenW-1] ? DenW'(-d_full) : d_full;
      s14_nmag     <= mulk_p[63] ? (64'd0 - mulk_p) : mulk_p;
      s14_side.neg <= mulk_p[63] ^ d_full[DenW-1];
      s14_side.inv <= d_full == '0;
    end
  end

  brc_div u_div (
    .clk(clk), .en(adv), .num(s14_nmag), .den(s14_dmag), .quo(quo_mag)
  );

  temp_side_t tside [0:74];
  div_side_t  dside [0:69];

  always_ff @(posedge clk) begin
    if (adv) begin
      tside[0] <= '{t16: s9_t16, report: s9_report};
      for (int i = 1; i < 75; i++) begin
        tside[i] <= tside[i-1];
      end
      dside[0] <= s14_side;
      for (int i = 1; i < 70; i++) begin
        dside[i] <= dside[i-1];
      end
    end
  end

  logic signed [63:0] s79_q, s80_q, s81_q, s82_q, s83_q;
  logic signed [63:0] s82_y2, s83_y2, s84_sum;
  logic        [63:0] mula_p, mulc_p, mulb_p;
  logic signed [31:0] pf;

  always_ff @(posedge clk) begin
    if (adv) begin
      s79_q   <= dside[63].neg ? $signed(64'd0 - quo_mag) : $signed(quo_mag);
      s80_q   <= s79_q;
      s81_q   <= s80_q;
      s82_q   <= s81_q;
      s83_q   <= s82_q;
      s82_y2  <= $signed(mulc_p) >>> 19;
      s83_y2  <= s82_y2;
      s84_sum <= s83_q + ($signed(mulb_p) >>> 25) + s83_y2;
    end
  end

  brc_mul64 u_mula (
    .clk(clk), .en(adv), .a(64'(p9)), .b(s79_q >>> 13), .p(mula_p)
  );
  brc_mul64 u_mulc (
    .clk(clk), .en(adv), .a(64'(p8)), .b(s79_q), .p(mulc_p)
  );
  brc_mul64 u_mulb (
    .clk(clk), .en(adv), .a(mula_p), .b(s81_q >>> 13), .p(mulb_p)
  );

  assign pf = 32'(s84_sum >>> 8) + (32'(p7) <<< 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'd0, tside[74].report, tside[74].t16,
                  dside[69].inv ? 24'd0 : pf[31:8]};
      m_tuser <= dside[69].inv;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/brc_mul64.sv
`default_nettype none
module brc_mul64 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] pp0;
  logic [31:0] pp1;
  logic [31:0] pp2;
  logic [63:0] lo_full;

  assign lo_full = a[31:0] * b[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp0 <= lo_full;
      pp1 <= 32'(a[31:0] * b[63:32]);
      pp2 <= 32'(a[63:32] * b[31:0]);
      p   <= pp0 + {pp1 + pp2, 32'd0};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/brc_div.sv
`default_nettype none
module brc_div (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [63:0]             num,
  input  wire logic [brc_pkg::DenW-1:0] den,
  output logic      [63:0]             quo
);
  import brc_pkg::*;

  logic [63:0]     w_q [0:DivSteps-1];
  logic [DenW-1:0] r_q [0:DivSteps-2];
  logic [DenW-1:0] d_q [0:DivSteps-2];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [63:0]     w_in;
    logic [DenW-1:0] r_in;
    logic [DenW-1:0] d_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign w_in = num;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign w_in = w_q[i-1];
      assign r_in = r_q[i-1];
      assign d_in = d_q[i-1];
    end

    assign trial = {r_in, w_in[63]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        w_q[i] <= {w_in[62:0], ge};
      end
    end

    if (i < DivSteps - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_q[i] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
          d_q[i] <= d_in;
        end
      end
    end
  end

  assign quo = w_q[DivSteps-1];

endmodule
`default_nettype wire

FILE: sim/barometer_reading_compensation_test.sv
`timescale 1ns / 100ps
`default_nettype none
module barometer_reading_compensation_test;
  import brc_pkg::*;

  typedef struct packed {
    logic [23:0] pressure_pa;
    logic        pressure_invalid;
    logic [15:0] temperature_centi;
    logic [11:0] temperature_report;
  } reading_t;

  typedef struct {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
    logic        known;
    reading_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_a, press_calib_b;
  logic [15:0] press_calib_c;

  reading_t pending_readings[$];
  int errors = 0;
  bit out_hold = 1'b0;
  bit out_calm = 1'b0;
  bit in_calm = 1'b0;

  barometer_reading_compensation i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("barometer_reading_compensation_test: done, errors");
    $finish;
  end

  function automatic logic signed [63:0] sx(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic reading_t compensate(logic [19:0] raw_p, logic [19:0] raw_t);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [127:0] a, b, v1, v2, fine_w, tw;
    logic signed [63:0] fine, x1, x2, p, ps, y1, y2, num, tsat, q;
    logic [63:0] mn, md;
    int tc;
    reading_t r;
    t1 = {48'd0, temp_calib[15:0]};
    t2 = sx(temp_calib[31:16]);
    t3 = sx(temp_calib[47:32]);
    p1 = {48'd0, press_calib_a[15:0]};
    p2 = sx(press_calib_a[31:16]);
    p3 = sx(press_calib_a[47:32]);
    p4 = sx(press_calib_a[63:48]);
    p5 = sx(press_calib_b[15:0]);
    p6 = sx(press_calib_b[31:16]);
    p7 = sx(press_calib_b[47:32]);
    p8 = sx(press_calib_b[63:48]);
    p9 = sx(press_calib_c);
    a = $signed({108'd0, raw_t[19:3]}) - 2 * t1;
    v1 = (a * t2) >>> 11;
    b = $signed({108'd0, raw_t[19:4]}) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    fine_w = v1 + v2;
    tw = (fine_w * 5 + 128) >>> 8;
    tsat = tw > 32767 ? 64'sd32767 : tw < -32768 ? -64'sd32768 : tw[63:0];
    tc = 32'(tsat);
    r.temperature_centi = tsat[15:0];
    r.temperature_report = tc < -4000 ? 12'd0 : 12'((tc + 4000) / 10);
    fine = fine_w[63:0];
    x1 = fine - 128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) <<< 17);
    x2 = x2 + (p4 <<< 35);
    x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
    x1 = (((64'sd1 <<< 47) + x1) * p1) >>> 33;
    r.pressure_pa = '0;
    r.pressure_invalid = x1 == 0;
    if (x1 != 0) begin
      p = 64'sd1048576 - $signed({44'd0, raw_p});
      num = ((p <<< 31) - x2) * 3125;
      mn = num[63] ? -num : num;
      md = x1[63] ? -x1 : x1;
      q = mn / md;
      p = (num[63] != x1[63]) ? -q : q;
      ps = p >>> 13;
      y1 = (p9 * ps * ps) >>> 25;
      y2 = (p8 * p) >>> 19;
      p = ((p + y1 + y2) >>> 8) + (p7 <<< 4);
      r.pressure_pa = p[31:8];
    end
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TEMP_CALIB: temp_calib = val[47:0];
      CFG_PRESS_CALIB_A: press_calib_a = val;
      CFG_PRESS_CALIB_B: press_calib_b = val;
      default: press_calib_c = val[15:0];
    endcase
  endtask

  task automatic send(logic [19:0] raw_p, logic [19:0] raw_t, bit known, reading_t want);
    while (!in_calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {raw_t, raw_p};
    do @(posedge clk); while (!s_tready);
    pending_readings.push_back(known ? want : compensate(raw_p, raw_t));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    reading_t got, exp_r;
    if (m_tvalid && m_tready) begin
      got.pressure_pa = m_tdata[23:0];
      got.pressure_invalid = m_tuser;
      got.temperature_centi = m_tdata[39:24];
      got.temperature_report = m_tdata[51:40];
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading %h", $time, got);
      end else begin
        exp_r = pending_readings.pop_front();
        if (got !== exp_r || m_tdata[55:52] !== 4'd0) begin
          errors++;
          $display("%0t: expected %h actual %h", $time, exp_r, got);
        end
      end
    end
    m_tready <= !out_hold && (out_calm || $urandom_range(99) >= 36);
  end

  function automatic reading_t rd(logic [23:0] p, bit inv, logic [15:0] t, logic [11:0] rep);
    reading_t r;
    r.pressure_pa = p;
    r.pressure_invalid = inv;
    r.temperature_centi = t;
    r.temperature_report = rep;
    return r;
  endfunction

  task automatic typical_calib();
    write_reg(CFG_TEMP_CALIB, 64'({16'd50, 16'd26435, 16'd27504}));
    write_reg(CFG_PRESS_CALIB_A, {16'd2855, 16'd140, 16'hD3D0, 16'd36477});
    write_reg(CFG_PRESS_CALIB_B, {16'hE874, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(CFG_PRESS_CALIB_C, 64'(16'd6000));
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    int mode;
    temp_calib = '0;
    press_calib_a = '0;
    press_calib_b = '0;
    press_calib_c = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All calibration words are zero after reset, so the divisor is zero.
    rows.push_back('{20'd0, 20'd0, 1'b1, rd(0, 1, 0, 400)});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, rd(0, 1, 0, 400)});
    foreach (rows[i]) send(rows[i].raw_p, rows[i].raw_t, rows[i].known, rows[i].want);
    drain();

    typical_calib();
    rows = {};
    rows.push_back('{20'd415148, 20'd519888, 1'b0, rd(0, 0, 0, 0)});
    rows.push_back('{20'd0, 20'd0, 1'b0, rd(0, 0, 0, 0)});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, rd(0, 0, 0, 0)});
    rows.push_back('{20'd0, 20'hFFFFF, 1'b0, rd(0, 0, 0, 0)});
    rows.push_back('{20'hFFFFF, 20'd0, 1'b0, rd(0, 0, 0, 0)});
    rows.push_back('{20'h55555, 20'hAAAAA, 1'b0, rd(0, 0, 0, 0)});
    rows.push_back('{20'hAAAAA, 20'h55555, 1'b0, rd(0, 0, 0, 0)});
    foreach (rows[i]) send(rows[i].raw_p, rows[i].raw_t, rows[i].known, rows[i].want);
    drain();

    // Extreme words: saturating temperature and a wrapped pressure path.
    write_reg(CFG_TEMP_CALIB, 64'(48'h7FFF_7FFF_FFFF));
    write_reg(CFG_PRESS_CALIB_A, 64'h8000_8000_7FFF_FFFF);
    write_reg(CFG_PRESS_CALIB_B, 64'h7FFF_8000_7FFF_8000);
    write_reg(CFG_PRESS_CALIB_C, 64'(16'h8000));
    send(20'd0, 20'hFFFFF, 1'b0, rd(0, 0, 0, 0));
    send(20'hFFFFF, 20'd0, 1'b0, rd(0, 0, 0, 0));
    drain();
    write_reg(CFG_TEMP_CALIB, 64'(48'h8000_8000_0000));
    send(20'h12345, 20'hFFFFF, 1'b0, rd(0, 0, 0, 0));
    send(20'h12345, 20'd0, 1'b0, rd(0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      mode = $urandom_range(2);
      if (mode == 0) typical_calib();
      else begin
        write_reg(CFG_TEMP_CALIB, {$urandom, $urandom});
        write_reg(CFG_PRESS_CALIB_A, {$urandom, $urandom});
        write_reg(CFG_PRESS_CALIB_B, {$urandom, $urandom});
        write_reg(CFG_PRESS_CALIB_C, 64'($urandom));
        if (mode == 2) write_reg(CFG_PRESS_CALIB_A, 64'({$urandom, 16'd0}));
      end
      in_calm = (ph == 3);
      out_calm = (ph == 3);
      if (ph == 5) begin
        fork
          begin
            out_hold = 1'b1;
            repeat (400) @(posedge clk);
            out_hold = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 250; k++) begin
        if (ph == 2 && k == 125) drain();
        if (mode == 0 && $urandom_range(3) != 0)
          send(20'(20'd415148 + $urandom_range(8191) - 4096),
               20'(20'd519888 + $urandom_range(8191) - 4096), 1'b0, r.want);
        else
          send(20'($urandom), 20'($urandom), 1'b0, r.want);
      end
      in_calm = 1'b0;
      out_calm = 1'b0;
      drain();
    end

    if (errors == 0) $display("barometer_reading_compensation_test: done, clean");
    else $display("barometer_reading_compensation_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/brc_pkg.sv
rtl/brc_mul64.sv
rtl/brc_div.sv
rtl/barometer_reading_compensation.sv
sim/barometer_reading_compensation_test.sv
